FILE: rtl/core/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [15:0] BMP_MAGIC      = 16'h4D42;
    localparam logic [31:0] BMP_INFO_SIZE  = 32'd40;
    localparam logic [15:0] BMP_BIT_DEPTH  = 16'd24;
    localparam logic [31:0] BMP_HDR_BYTES  = 32'd54;
    localparam logic [31:0] BMP_HDR_LAST   = 32'd53;

    typedef enum logic [2:0] {
        ST_PIXEL   = 3'd0,
        ST_MAGIC   = 3'd1,
        ST_HDRSIZE = 3'd2,
        ST_FORMAT  = 3'd3,
        ST_DIMS    = 3'd4,
        ST_TRUNC   = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PIXELS = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_HALT   = 5'b10000
    } phase_t;

    // header check result handed to the stream control
    typedef struct packed {
        status_t status;
        logic    top_down;
        logic    off_is_54;
    } bmpd_hdr_t;

endpackage

FILE: rtl/core/bmpd_hdr.sv
// ----------------------------------------------------------------------------
// bmpd_hdr
// Captures the header fields of the file and info headers, checks them and
// derives the image geometry used while pixels are decoded.
// ----------------------------------------------------------------------------
module bmpd_hdr
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cap_en,
    input  logic [5:0]                           cap_pos,
    input  logic [7:0]                           cap_byte,
    output bmpd_hdr_t                            info,
    output logic [31:0]                          data_offset,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]     w_m1,
    output logic [$clog2(MAX_HEIGHT + 1)-1:0]    h_m1,
    output logic [$clog2(3 * MAX_WIDTH + 4)-1:0] data_len,
    output logic [$clog2(3 * MAX_WIDTH + 4)-1:0] row_len
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int RB_W  = $clog2(3 * MAX_WIDTH + 4);

    logic [15:0] magic_reg, magic_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] isize_reg, isize_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] comp_reg, comp_next;

    bmpd_hdr_t         info_reg, info_next;
    logic [COL_W-1:0]  w_m1_reg, w_m1_next;
    logic [ROW_W-1:0]  h_m1_reg, h_m1_next;
    logic [RB_W-1:0]   dlen_reg, dlen_next;
    logic [RB_W-1:0]   rlen_reg, rlen_next;

    logic [31:0] height_mag;
    logic [33:0] len_mul;
    logic [33:0] len_pad;
    logic [5:0]  lane;

    // byte capture, little endian fields
    always_comb
    begin
        magic_next  = magic_reg;
        offset_next = offset_reg;
        isize_next  = isize_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        comp_next   = comp_reg;
        lane        = 6'd0;
        if (cap_en)
        begin
            if (cap_pos < 6'd2)
            begin
                lane = cap_pos;
                magic_next[8 * lane[0] +: 8] = cap_byte;
            end
            else if (cap_pos >= 6'd10 && cap_pos < 6'd14)
            begin
                lane = cap_pos - 6'd10;
                offset_next[8 * lane[1:0] +: 8] = cap_byte;
            end
            else if (cap_pos >= 6'd14 && cap_pos < 6'd18)
            begin
                lane = cap_pos - 6'd14;
                isize_next[8 * lane[1:0] +: 8] = cap_byte;
            end
            else if (cap_pos >= 6'd18 && cap_pos < 6'd22)
            begin
                lane = cap_pos - 6'd18;
                width_next[8 * lane[1:0] +: 8] = cap_byte;
            end
            else if (cap_pos >= 6'd22 && cap_pos < 6'd26)
            begin
                lane = cap_pos - 6'd22;
                height_next[8 * lane[1:0] +: 8] = cap_byte;
            end
            else if (cap_pos >= 6'd28 && cap_pos < 6'd30)
            begin
                lane = cap_pos - 6'd28;
                depth_next[8 * lane[0] +: 8] = cap_byte;
            end
            else if (cap_pos >= 6'd30 && cap_pos < 6'd34)
            begin
                lane = cap_pos - 6'd30;
                comp_next[8 * lane[1:0] +: 8] = cap_byte;
            end
        end
    end

    // fields settle by byte 33; the check reads the captured field registers and its result is registered
    always_comb
    begin
        height_mag = height_reg[31] ? (~height_reg + 32'd1) : height_reg;
        len_mul    = {2'b00, width_reg} + {1'b0, width_reg, 1'b0};
        len_pad    = (len_mul + 34'd3) & ~34'd3;

        info_next.top_down  = height_reg[31];
        info_next.off_is_54 = (offset_reg == BMP_HDR_BYTES);
        if (magic_reg != BMP_MAGIC)
            info_next.status = ST_MAGIC;
        else if (isize_reg != BMP_INFO_SIZE)
            info_next.status = ST_HDRSIZE;
        else if (depth_reg != BMP_BIT_DEPTH || comp_reg != 32'd0)
            info_next.status = ST_FORMAT;
        else if (width_reg[31] || width_reg == 32'd0 || height_reg == 32'd0)
            info_next.status = ST_DIMS;
        else if (width_reg > 32'(MAX_WIDTH) || height_mag > 32'(MAX_HEIGHT))
            info_next.status = ST_DIMS;
        else if (offset_reg < BMP_HDR_BYTES)
            info_next.status = ST_HDRSIZE;
        else
            info_next.status = ST_PIXEL;

        w_m1_next = COL_W'(width_reg - 32'd1);
        h_m1_next = ROW_W'(height_mag - 32'd1);
        dlen_next = RB_W'(len_mul);
        rlen_next = RB_W'(len_pad);
    end

    always_ff @(posedge clk)
    begin
        magic_reg  <= magic_next;
        offset_reg <= offset_next;
        isize_reg  <= isize_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        depth_reg  <= depth_next;
        comp_reg   <= comp_next;
        w_m1_reg   <= w_m1_next;
        h_m1_reg   <= h_m1_next;
        dlen_reg   <= dlen_next;
        rlen_reg   <= rlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg <= '{status: ST_PIXEL, top_down: 1'b0, off_is_54: 1'b0};
        end
        else
        begin
            info_reg <= info_next;
        end
    end

    assign info        = info_reg;
    assign data_offset = offset_reg;
    assign w_m1        = w_m1_reg;
    assign h_m1        = h_m1_reg;
    assign data_len    = dlen_reg;
    assign row_len     = rlen_reg;

endmodule

FILE: rtl/core/bmp24_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files, one byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one file byte in every clock cycle while in_ready is high
// and produces at most one result per byte: a pixel on the third byte of each
// stored BGR triple, or a single error transaction (bad magic, bad header,
// unsupported format, bad dimensions, truncation) after which it ignores bytes
// until start_of_file. Each byte is finished in the cycle it is accepted; the
// phase, position and row/column counters update in that cycle and the result
// lands in an output register, so a byte can be accepted as a waiting result
// is taken. in_ready drops only while that output register is full and stalled.
// Rows stored bottom-up are flipped in image_row, and row padding is dropped.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [11:0] column,
    output logic [11:0] image_row,
    output logic [2:0]  status,
    output logic        last_pixel
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int RB_W  = $clog2(3 * MAX_WIDTH + 4);

    phase_t            phase_reg, phase_next, phase_cur;
    logic [31:0]       pos_reg, pos_next, pos_cur, pos_inc;
    logic [1:0]        cp_reg, cp_next;
    logic [7:0]        held_blue_reg, held_blue_next;
    logic [7:0]        held_green_reg, held_green_next;
    logic [RB_W-1:0]   rb_reg, rb_next, rb_inc;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next, y_pix;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;
    logic [11:0]       column_reg, column_next;
    logic [11:0]       image_row_reg, image_row_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              emit_pix;
    logic              emit_err;
    status_t           err_code;
    logic              is_last;

    bmpd_hdr_t         hdr;
    logic [31:0]       data_offset;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [RB_W-1:0]   data_len;
    logic [RB_W-1:0]   row_len;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // a start of file restarts parsing on this very byte
    assign phase_cur = start_of_file ? PH_HEADER : phase_reg;
    assign pos_cur   = start_of_file ? 32'd0 : pos_reg;

    bmpd_hdr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_hdr (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap_en      (accept && phase_cur == PH_HEADER),
        .cap_pos     (pos_cur[5:0]),
        .cap_byte    (data_byte),
        .info        (hdr),
        .data_offset (data_offset),
        .w_m1        (w_m1),
        .h_m1        (h_m1),
        .data_len    (data_len),
        .row_len     (row_len)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        cp_next         = cp_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        rb_next         = rb_reg;
        col_next        = col_reg;
        row_next        = row_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        column_next     = column_reg;
        image_row_next  = image_row_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        emit_pix = 1'b0;
        emit_err = 1'b0;
        err_code = ST_TRUNC;
        pos_inc  = pos_cur + 32'd1;
        rb_inc   = rb_reg + RB_W'(1);
        is_last  = (col_reg == w_m1) && (row_reg == h_m1);
        y_pix    = hdr.top_down ? row_reg : (h_m1 - row_reg);

        if (accept)
        begin
            unique case (phase_cur)
                PH_HEADER:
                begin
                    cp_next  = 2'd0;
                    rb_next  = '0;
                    col_next = '0;
                    row_next = '0;
                    if (pos_cur == BMP_HDR_LAST)
                    begin
                        if (hdr.status != ST_PIXEL)
                        begin
                            emit_err   = 1'b1;
                            err_code   = hdr.status;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            pos_next   = BMP_HDR_BYTES;
                            phase_next = hdr.off_is_54 ? PH_PIXELS : PH_SKIP;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        phase_next = PH_HEADER;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= data_offset)
                        phase_next = PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    if (rb_reg < data_len)
                    begin
                        unique case (cp_reg)
                            2'd0:
                            begin
                                held_blue_next = data_byte;
                                cp_next        = 2'd1;
                            end
                            2'd1:
                            begin
                                held_green_next = data_byte;
                                cp_next         = 2'd2;
                            end
                            default:
                            begin
                                emit_pix = 1'b1;
                                cp_next  = 2'd0;
                                col_next = col_reg + COL_W'(1);
                                if (is_last)
                                    phase_next = PH_DONE;
                            end
                        endcase
                    end
                    rb_next = rb_inc;
                    // end of stored row, padding included
                    if (rb_inc >= row_len)
                    begin
                        rb_next  = '0;
                        col_next = '0;
                        cp_next  = 2'd0;
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                PH_DONE, PH_HALT:
                begin
                    phase_next = phase_cur;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase

            // early end of file replaces a pixel completed by the same byte
            if (end_of_file && phase_cur != PH_DONE && phase_cur != PH_HALT
                && phase_next != PH_DONE && phase_next != PH_HALT)
            begin
                emit_pix   = 1'b0;
                emit_err   = 1'b1;
                err_code   = ST_TRUNC;
                phase_next = PH_HALT;
            end

            if (emit_pix)
            begin
                out_valid_next = 1'b1;
                red_next       = data_byte;
                green_next     = held_green_reg;
                blue_next      = held_blue_reg;
                column_next    = 12'(col_reg);
                image_row_next = 12'(y_pix);
                status_next    = ST_PIXEL;
                last_next      = is_last;
            end
            else if (emit_err)
            begin
                out_valid_next = 1'b1;
                red_next       = 8'd0;
                green_next     = 8'd0;
                blue_next      = 8'd0;
                column_next    = 12'd0;
                image_row_next = 12'd0;
                status_next    = err_code;
                last_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 32'd0;
            cp_reg        <= 2'd0;
            rb_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cp_reg        <= cp_next;
            rb_reg        <= rb_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_blue_reg  <= held_blue_next;
        held_green_reg <= held_green_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        column_reg     <= column_next;
        image_row_reg  <= image_row_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign column     = column_reg;
    assign image_row  = image_row_reg;
    assign status     = status_reg;
    assign last_pixel = last_reg;

endmodule

FILE: sim/tb_bmp24_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp24_stream_decoder
// Self-checking testbench for the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
// Whole BMP files are built in a byte queue and streamed into the decoder one
// byte per input transaction. A behavioral decoder inside the testbench tracks
// the header, skip and pixel phases and queues the pixel or error transaction
// that each accepted byte should produce. A checker compares every output
// transaction field by field against that queue. Directed files cover the
// header checks, truncation, restarts and the largest sizes. Random files and
// random sender gaps and receiver stalls follow.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_decoder;
    import bmpd_pkg::*;

    localparam int MAX_W           = DEF_MAX_WIDTH;
    localparam int MAX_H           = DEF_MAX_HEIGHT;
    localparam int HDR_LEN         = BMP_HDR_BYTES;
    localparam int OFS_MAGIC       = 0;
    localparam int OFS_DATA_OFFSET = 10;
    localparam int OFS_INFO_SIZE   = 14;
    localparam int OFS_WIDTH       = 18;
    localparam int OFS_HEIGHT      = 22;
    localparam int OFS_BIT_DEPTH   = 28;
    localparam int OFS_COMPRESSION = 30;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_TAIL      = 10;
    localparam int REPORT_MAX      = 60;
    localparam int RANDOM_BYTES    = 500;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        status_t     status;
        logic        last;
    } decode_result_t;

    typedef enum {RX_STEADY, RX_RANDOM, RX_TOGGLE} rx_pattern_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        end_of_file;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] image_row;
    logic [2:0]  status;
    logic        last_pixel;

    // decoder state mirrored by the testbench
    phase_t      phase;
    logic [31:0] byte_pos;
    logic [15:0] hdr_magic;
    logic [31:0] hdr_offset;
    logic [31:0] hdr_info;
    logic [31:0] hdr_width;
    logic [31:0] hdr_height;
    logic [15:0] hdr_depth;
    logic [31:0] hdr_compr;
    logic [1:0]  color_idx;
    logic [7:0]  blue_hold;
    logic [7:0]  green_hold;
    logic [31:0] row_bytes;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic        top_down;

    decode_result_t pending_decodes[$];
    logic [7:0]     file_bytes[$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int live_bytes  = 0;
    bit gaps_on     = 1'b1;
    bit hold_req    = 1'b0;

    bmp24_stream_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .column        (column),
        .image_row     (image_row),
        .status        (status),
        .last_pixel    (last_pixel)
    );

    always #2 clk = ~clk;

    function automatic void restart_decoder();
        phase      = PH_HEADER;
        byte_pos   = '0;
        hdr_magic  = '0;
        hdr_offset = '0;
        hdr_info   = '0;
        hdr_width  = '0;
        hdr_height = '0;
        hdr_depth  = '0;
        hdr_compr  = '0;
        color_idx  = '0;
        blue_hold  = '0;
        green_hold = '0;
        row_bytes  = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        top_down   = 1'b0;
    endfunction

    function automatic logic [31:0] height_abs();
        return hdr_height[31] ? (~hdr_height + 32'd1) : hdr_height;
    endfunction

    function automatic decode_result_t pack_result(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b, input logic [11:0] col,
                                                   input logic [11:0] row, input status_t st,
                                                   input logic last);
        decode_result_t res;
        res.red    = r;
        res.green  = g;
        res.blue   = b;
        res.column = col;
        res.row    = row;
        res.status = st;
        res.last   = last;
        return res;
    endfunction

    // advances the mirrored decoder by one byte; returns 0 when the byte is ignored
    function automatic bit decode_byte(input logic [7:0] b, input bit sof, input bit eof);
        decode_result_t res;
        bit             has_res;
        status_t        st;
        logic [31:0]    w;
        logic [31:0]    h;
        logic [31:0]    data_len;
        logic [31:0]    row_len;
        logic [31:0]    y;
        logic           last;
        has_res = 1'b0;
        if (sof)
            restart_decoder();
        if (phase == PH_DONE || phase == PH_HALT)
            return 1'b0;
        case (phase)
            PH_HEADER:
            begin
                if (byte_pos < OFS_MAGIC + 2)
                    hdr_magic[8*(byte_pos - OFS_MAGIC) +: 8] = b;
                else if (byte_pos >= OFS_DATA_OFFSET && byte_pos < OFS_DATA_OFFSET + 4)
                    hdr_offset[8*(byte_pos - OFS_DATA_OFFSET) +: 8] = b;
                else if (byte_pos >= OFS_INFO_SIZE && byte_pos < OFS_INFO_SIZE + 4)
                    hdr_info[8*(byte_pos - OFS_INFO_SIZE) +: 8] = b;
                else if (byte_pos >= OFS_WIDTH && byte_pos < OFS_WIDTH + 4)
                    hdr_width[8*(byte_pos - OFS_WIDTH) +: 8] = b;
                else if (byte_pos >= OFS_HEIGHT && byte_pos < OFS_HEIGHT + 4)
                    hdr_height[8*(byte_pos - OFS_HEIGHT) +: 8] = b;
                else if (byte_pos >= OFS_BIT_DEPTH && byte_pos < OFS_BIT_DEPTH + 2)
                    hdr_depth[8*(byte_pos - OFS_BIT_DEPTH) +: 8] = b;
                else if (byte_pos >= OFS_COMPRESSION && byte_pos < OFS_COMPRESSION + 4)
                    hdr_compr[8*(byte_pos - OFS_COMPRESSION) +: 8] = b;

                if (byte_pos == BMP_HDR_LAST)
                begin
                    if (hdr_magic != BMP_MAGIC)
                        st = ST_MAGIC;
                    else if (hdr_info != BMP_INFO_SIZE)
                        st = ST_HDRSIZE;
                    else if (hdr_depth != BMP_BIT_DEPTH || hdr_compr != 0)
                        st = ST_FORMAT;
                    else if (hdr_width[31] || hdr_width == 0 || hdr_height == 0)
                        st = ST_DIMS;
                    else if (hdr_width > MAX_W || height_abs() > MAX_H)
                        st = ST_DIMS;
                    else if (hdr_offset < BMP_HDR_BYTES)
                        st = ST_HDRSIZE;
                    else
                        st = ST_PIXEL;
                    // a header error wins over end_of_file on the same byte
                    if (st != ST_PIXEL)
                    begin
                        pending_decodes.push_back(pack_result(0, 0, 0, 0, 0, st, 1'b0));
                        phase = PH_HALT;
                        return 1'b1;
                    end
                    top_down = hdr_height[31];
                    byte_pos = BMP_HDR_BYTES;
                    phase    = (hdr_offset == BMP_HDR_BYTES) ? PH_PIXELS : PH_SKIP;
                end
                else
                begin
                    byte_pos++;
                end
            end
            PH_SKIP:
            begin
                byte_pos++;
                if (byte_pos >= hdr_offset)
                    phase = PH_PIXELS;
            end
            default:
            begin
                w        = hdr_width;
                h        = height_abs();
                data_len = w * 3;
                row_len  = (data_len + 3) & ~32'd3;
                if (row_bytes < data_len)
                begin
                    if (color_idx == 0)
                    begin
                        blue_hold = b;
                        color_idx = 1;
                    end
                    else if (color_idx == 1)
                    begin
                        green_hold = b;
                        color_idx  = 2;
                    end
                    else
                    begin
                        y    = top_down ? row_cnt : (h - 1 - row_cnt);
                        last = (col_cnt == w - 1) && (row_cnt == h - 1);
                        res  = pack_result(b, green_hold, blue_hold, col_cnt[11:0], y[11:0],
                                           ST_PIXEL, last);
                        has_res   = 1'b1;
                        color_idx = 0;
                        col_cnt++;
                        if (last)
                            phase = PH_DONE;
                    end
                end
                // padding bytes fall through here and only advance the row byte count
                row_bytes++;
                if (row_bytes >= row_len)
                begin
                    row_bytes = 0;
                    col_cnt   = 0;
                    color_idx = 0;
                    row_cnt++;
                end
            end
        endcase
        // early end of file replaces a pixel finished by the same byte
        if (eof && phase != PH_DONE && phase != PH_HALT)
        begin
            res     = pack_result(0, 0, 0, 0, 0, ST_TRUNC, 1'b0);
            has_res = 1'b1;
            phase   = PH_HALT;
        end
        if (has_res)
            pending_decodes.push_back(res);
        return 1'b1;
    endfunction

    function automatic void put_le(input int at, input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            file_bytes[at + k] = v[8*k +: 8];
    endfunction

    // valid header with random filler, the gap up to the data offset, and pixel rows
    function automatic void build_image(input int w, input int h, input int off,
                                        input bit pad_last);
        int rows;
        int row_len;
        file_bytes.delete();
        repeat (HDR_LEN) file_bytes.push_back($urandom_range(0, 255));
        put_le(OFS_MAGIC, BMP_MAGIC, 2);
        put_le(OFS_DATA_OFFSET, off, 4);
        put_le(OFS_INFO_SIZE, BMP_INFO_SIZE, 4);
        put_le(OFS_WIDTH, w, 4);
        put_le(OFS_HEIGHT, h, 4);
        put_le(OFS_BIT_DEPTH, BMP_BIT_DEPTH, 2);
        put_le(OFS_COMPRESSION, 0, 4);
        repeat (off - HDR_LEN) file_bytes.push_back($urandom_range(0, 255));
        rows    = (h < 0) ? -h : h;
        row_len = (w * 3 + 3) / 4 * 4;
        for (int r = 0; r < rows; r++)
        begin
            for (int k = 0; k < row_len; k++)
            begin
                if (k < w * 3 || r < rows - 1 || pad_last)
                    file_bytes.push_back($urandom_range(0, 255));
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] value, input bit sof, input bit eof);
        @(negedge clk);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid      = 1'b1;
        data_byte     = value;
        start_of_file = sof;
        end_of_file   = eof;
        do
            @(posedge clk);
        while (!in_ready);
        if (decode_byte(value, sof, eof))
            live_bytes++;
    endtask

    // streams file_bytes, stopping after the byte that carries end_of_file
    task automatic send_file(input bit with_sof, input int eof_at, input int count);
        int n;
        n = (count < 0 || count > file_bytes.size()) ? file_bytes.size() : count;
        if (eof_at >= 0 && eof_at + 1 < n)
            n = eof_at + 1;
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], with_sof && i == 0, i == eof_at);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (pending_decodes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic test_plain_images();
        // first file after reset comes without start_of_file
        build_image(2, 2, HDR_LEN, 1'b1);
        for (int k = 0; k < 3; k++)
        begin
            file_bytes[HDR_LEN + k]     = 8'h00;
            file_bytes[HDR_LEN + 3 + k] = 8'hFF;
        end
        send_file(1'b0, file_bytes.size() - 1, -1);
        // top-down with skipped bytes, last row without padding, eof on the final pixel
        build_image(3, -2, HDR_LEN + 4, 1'b0);
        send_file(1'b1, file_bytes.size() - 1, -1);
        // bytes and eof after the image is complete are ignored
        build_image(1, 1, HDR_LEN, 1'b1);
        send_file(1'b1, -1, -1);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        wait_results_done();
    endtask

    task automatic test_header_errors();
        for (int c = 0; c < 12; c++)
        begin
            build_image(2, 2, HDR_LEN, 1'b1);
            case (c)
                0:  put_le(OFS_MAGIC, BMP_MAGIC ^ 16'h0001, 2);
                1:  put_le(OFS_INFO_SIZE, 12, 4);
                2:  put_le(OFS_BIT_DEPTH, 32, 2);
                3:  put_le(OFS_COMPRESSION, 1, 4);
                4:  put_le(OFS_WIDTH, 0, 4);
                5:  put_le(OFS_WIDTH, 32'h8000_0001, 4);
                6:  put_le(OFS_HEIGHT, 0, 4);
                7:  put_le(OFS_WIDTH, MAX_W + 1, 4);
                8:  put_le(OFS_HEIGHT, MAX_H + 1, 4);
                9:  put_le(OFS_HEIGHT, -(MAX_H + 1), 4);
                10: put_le(OFS_DATA_OFFSET, HDR_LEN - 1, 4);
                default:
                begin
                    // several faults at once, magic is checked first
                    put_le(OFS_MAGIC, 0, 2);
                    put_le(OFS_INFO_SIZE, 0, 4);
                end
            endcase
            // odd cases end the file on the last header byte, even ones after the error
            send_file(1'b1, (c % 2) ? HDR_LEN - 1 : HDR_LEN + 4, HDR_LEN + 6);
        end
        wait_results_done();
    endtask

    task automatic test_truncation();
        // header, header end, skip, mid triple, pixel-completing byte, row padding
        int cut_points[6] = '{20, HDR_LEN - 1, HDR_LEN + 3, HDR_LEN + 7, HDR_LEN + 8,
                              HDR_LEN + 16};
        foreach (cut_points[i])
        begin
            build_image(3, 2, HDR_LEN + 6, 1'b1);
            send_file(1'b1, cut_points[i], -1);
        end
        wait_results_done();
    endtask

    task automatic test_restart();
        build_image(3, 2, HDR_LEN, 1'b1);
        send_file(1'b1, -1, 20);
        build_image(1, 2, HDR_LEN + 2, 1'b1);
        send_file(1'b1, -1, HDR_LEN + 1);
        build_image(3, 2, HDR_LEN + 3, 1'b1);
        send_file(1'b1, -1, 70);
        build_image(2, -1, HDR_LEN, 1'b0);
        send_file(1'b1, file_bytes.size() - 1, -1);
        wait_results_done();
    endtask

    task automatic test_output_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        build_image(4, 3, HDR_LEN, 1'b1);
        send_file(1'b1, file_bytes.size() - 1, -1);
        wait_results_done();
        gaps_on = 1'b1;
    endtask

    task automatic test_largest_images();
        // widest image: header accepted, first pixels of the row, then cut short
        build_image(MAX_W, 1, HDR_LEN, 1'b1);
        send_file(1'b1, HDR_LEN + 29, -1);
        // tallest bottom-up image: first rows land at the highest row numbers
        build_image(1, MAX_H, HDR_LEN, 1'b1);
        send_file(1'b1, HDR_LEN + 11, -1);
        wait_results_done();
    endtask

    task automatic test_random_files();
        int w;
        int h;
        int off;
        int kind;
        int eof_at;
        live_bytes = 0;
        while (live_bytes < RANDOM_BYTES)
        begin
            w    = $urandom_range(1, 6);
            h    = $urandom_range(1, 4);
            h    = $urandom_range(0, 1) ? -h : h;
            off  = ($urandom_range(0, 2) == 0) ? HDR_LEN : HDR_LEN + $urandom_range(1, 6);
            build_image(w, h, off, $urandom_range(0, 1));
            kind   = $urandom_range(0, 99);
            eof_at = -1;
            if (kind < 70)
            begin
                if ($urandom_range(0, 1))
                    eof_at = file_bytes.size() - 1;
            end
            else if (kind < 85)
            begin
                eof_at = $urandom_range(0, file_bytes.size() - 1);
            end
            else
            begin
                file_bytes[$urandom_range(0, HDR_LEN - 1)] = $urandom_range(0, 255);
                if ($urandom_range(0, 1))
                    eof_at = $urandom_range(0, file_bytes.size() - 1);
            end
            send_file($urandom_range(0, 9) != 0, eof_at, -1);
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte($urandom_range(0, 255), 1'b0, $urandom_range(0, 1));
            end
        end
        wait_results_done();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        start_of_file = 1'b0;
        end_of_file   = 1'b0;
        restart_decoder();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plain_images();
        test_header_errors();
        test_truncation();
        test_restart();
        test_output_backpressure();
        test_largest_images();
        test_random_files();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver: stretches of steady, random and alternating ready, plus one long hold
    initial
    begin : receiver
        rx_pattern_t pattern;
        int          seg_left;
        out_ready = 1'b0;
        seg_left  = 0;
        pattern   = RX_STEADY;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                pattern  = rx_pattern_t'($urandom_range(0, 2));
            end
            seg_left--;
            case (pattern)
                RX_STEADY: out_ready = 1'b1;
                RX_RANDOM: out_ready = ($urandom_range(0, 99) >= 35);
                default:   out_ready = ~out_ready;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        decode_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: unexpected transaction, expected none, actual status %0d",
                             $time, status);
            end
            else
            begin
                want = pending_decodes.pop_front();
                compare_field("red", want.red, red);
                compare_field("green", want.green, green);
                compare_field("blue", want.blue, blue);
                compare_field("column", want.column, column);
                compare_field("image_row", want.row, image_row);
                compare_field("status", want.status, status);
                compare_field("last_pixel", want.last, last_pixel);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
